FILE: hw/rtl/jeab_pkg.sv
// ----------------------------------------------------------------------------
// jeab_pkg
// Shared types and constants of the joystick event decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jeab_pkg;

  // Event types of the input stream.
  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_ABS = 16'd3;

  // Axis shaping constants.
  localparam int unsigned SCALE = 2000;
  localparam int unsigned HALF  = 1000;
  // Division by 1000 of a value below 2^20 as (m * RECIP_K) >> RECIP_SHIFT.
  localparam logic [30:0] RECIP_K     = 31'd1099511628;
  localparam int unsigned RECIP_SHIFT = 40;

  // Register indexes (byte address / 4).
  typedef enum logic [2:0] {
    REG_X_SEL = 3'd0,
    REG_Y_SEL = 3'd1,
    REG_X_MIN = 3'd2,
    REG_X_MAX = 3'd3,
    REG_Y_MIN = 3'd4,
    REG_Y_MAX = 3'd5,
    REG_MASK  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_BIG   = 2'd2,
    ST_AXIS  = 2'd3
  } status_t;

  // Class of a request as decided by the front end.
  typedef enum logic [2:0] {
    K_NOP    = 3'd0,
    K_CAP    = 3'd1,
    K_AXIS   = 3'd2,
    K_AXBAD  = 3'd3,
    K_KEY    = 3'd4,
    K_KEYBAD = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  code;
    logic [31:0]  value;
    logic [4:0]   widx;
    logic [31:0]  word;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         x_sel;
    logic [3:0]         y_sel;
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic signed [31:0] y_min;
    logic signed [31:0] y_max;
    logic [8:0]         mask;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/jeab_regs.sv
// ----------------------------------------------------------------------------
// jeab_regs
// APB register file holding axis selection, axis ranges and the axis mask.
// ----------------------------------------------------------------------------
`default_nettype none

module jeab_regs
  import jeab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_X_SEL: cfg_nxt.x_sel = cfg_pwdata[3:0];
        REG_Y_SEL: cfg_nxt.y_sel = cfg_pwdata[3:0];
        REG_X_MIN: cfg_nxt.x_min = cfg_pwdata;
        REG_X_MAX: cfg_nxt.x_max = cfg_pwdata;
        REG_Y_MIN: cfg_nxt.y_min = cfg_pwdata;
        REG_Y_MAX: cfg_nxt.y_max = cfg_pwdata;
        REG_MASK:  cfg_nxt.mask  = cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_SEL: cfg_prdata = {28'd0, cfg_r.x_sel};
      REG_Y_SEL: cfg_prdata = {28'd0, cfg_r.y_sel};
      REG_X_MIN: cfg_prdata = cfg_r.x_min;
      REG_X_MAX: cfg_prdata = cfg_r.x_max;
      REG_Y_MIN: cfg_prdata = cfg_r.y_min;
      REG_Y_MAX: cfg_prdata = cfg_r.y_max;
      REG_MASK:  cfg_prdata = {23'd0, cfg_r.mask};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_sel <= 4'd0;
      cfg_r.y_sel <= 4'd1;
      cfg_r.x_min <= 32'sd0;
      cfg_r.x_max <= 32'sd255;
      cfg_r.y_min <= 32'sd0;
      cfg_r.y_max <= 32'sd255;
      cfg_r.mask  <= 9'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jeab_front.sv
// ----------------------------------------------------------------------------
// jeab_front
// Accepts input items and classifies them into requests for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jeab_front
  import jeab_pkg::*;
#(
  parameter int KEY_BITS   = 768,
  parameter int AXIS_COUNT = 9
)
(
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         q_full,
  output logic              q_push,
  output cmd_t              cmd
);

  localparam int KEY_WORDS = (KEY_BITS + 31) / 32;

  logic [15:0] ev_type;
  logic [15:0] ev_code;

  assign ev_type   = in_tdata[15:0];
  assign ev_code   = in_tdata[31:16];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    cmd.code  = ev_code;
    cmd.value = in_tdata[63:32];
    cmd.widx  = in_tdata[68:64];
    cmd.word  = in_tdata[100:69];
    priority if (in_tuser) begin
      cmd.kind = (32'(cmd.widx) < KEY_WORDS) ? K_CAP : K_NOP;
    end else if (ev_type == EV_ABS) begin
      cmd.kind = (32'(ev_code) < AXIS_COUNT) ? K_AXIS : K_AXBAD;
    end else if (ev_type == EV_KEY) begin
      cmd.kind = (32'(ev_code) < KEY_BITS) ? K_KEY : K_KEYBAD;
    end else begin
      cmd.kind = K_NOP;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jeab_fifo.sv
// ----------------------------------------------------------------------------
// jeab_fifo
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jeab_fifo #(
  parameter int WIDTH = 8
)
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      head
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_pop;

  assign full   = cnt_r == 2'd2;
  assign valid  = cnt_r != 2'd0;
  assign head   = mem_r[rp_r];
  assign do_pop = pop && valid;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jeab_back.sv
// ----------------------------------------------------------------------------
// jeab_back
// Executes requests: state updates, button rank sweep and axis shaping.
// ----------------------------------------------------------------------------
`default_nettype none

module jeab_back
  import jeab_pkg::*;
#(
  parameter int KEY_BITS   = 768,
  parameter int AXIS_COUNT = 9
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata
);

  localparam int KEY_WORDS = (KEY_BITS + 31) / 32;
  localparam int KW        = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int AW        = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int RW        = $clog2(KEY_BITS + 1);

  typedef enum logic [10:0] {
    B_IDLE  = 11'b00000000001,
    B_EXEC  = 11'b00000000010,
    B_RANK  = 11'b00000000100,
    B_LOAD  = 11'b00000001000,
    B_MUL   = 11'b00000010000,
    B_CHK   = 11'b00000100000,
    B_DIV   = 11'b00001000000,
    B_CLAMP = 11'b00010000000,
    B_SQ    = 11'b00100000000,
    B_REC   = 11'b01000000000,
    B_OUT   = 11'b10000000000
  } bstate_t;

  function automatic logic [5:0] popcnt(input logic [31:0] w);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      n = n + {5'd0, w[i]};
    end
    return n;
  endfunction

  bstate_t            state_r, state_nxt;
  logic [31:0]        cap_r [KEY_WORDS];
  logic signed [31:0] raw_r [AXIS_COUNT];
  logic [31:0]        btn_r, btn_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_data_r, out_data_nxt;
  logic               cap_we, raw_we;

  status_t            status_r, status_nxt;
  logic               span_r, span_nxt;
  logic               ax_r, ax_nxt;
  logic [KW-1:0]      widx_r, widx_nxt;
  logic [RW-1:0]      rank_r, rank_nxt;
  logic [32:0]        dmag_r, dmag_nxt;
  logic [32:0]        smag_r, smag_nxt;
  logic               qneg_r, qneg_nxt;
  logic [43:0]        nmag_r, nmag_nxt;
  logic [43:0]        dvs_r, dvs_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [10:0]        q_r, q_nxt;
  logic signed [10:0] v_r, v_nxt;
  logic [19:0]        sq_r, sq_nxt;
  logic               vneg_r, vneg_nxt;
  logic signed [10:0] xpos_r, xpos_nxt;
  logic signed [10:0] ypos_r, ypos_nxt;

  // Working signals.
  logic [31:0]        word;
  logic               last_word;
  logic [4:0]         bitsel;
  logic [5:0]         pc;
  logic [RW-1:0]      rank_sum;
  logic [3:0]         sel;
  logic               sel_ok;
  logic [15:0]        mask16;
  logic signed [31:0] lo, hi, raw;
  logic signed [32:0] span, diff;
  logic signed [12:0] qs, t;
  logic [9:0]         vmag;
  logic [50:0]        prod;
  logic [9:0]         p;
  logic               axis_done;
  logic signed [10:0] axis_pos;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign word      = cap_r[widx_r];
  assign bitsel    = cmd.code[4:0];
  assign last_word = widx_r == cmd.code[5 +: KW];
  assign pc        = popcnt(last_word ? (word & ((32'd1 << bitsel) - 32'd1)) : word);
  assign rank_sum  = rank_r + RW'(pc);

  assign sel    = ax_r ? cfg.y_sel : cfg.x_sel;
  assign lo     = ax_r ? cfg.y_min : cfg.x_min;
  assign hi     = ax_r ? cfg.y_max : cfg.x_max;
  assign mask16 = {7'd0, cfg.mask};
  // Axes at or beyond the mask width are always absent.
  assign sel_ok = (32'(sel) < AXIS_COUNT) && mask16[sel];
  assign raw    = raw_r[sel[AW-1:0]];
  assign span   = 33'(hi) - 33'(lo);
  assign diff   = 33'(raw) - 33'(lo);

  assign qs   = qneg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign t    = qs - 13'sd1000;
  assign vmag = v_r[10] ? 10'(-v_r) : v_r[9:0];
  assign prod = {31'd0, sq_r} * {20'd0, RECIP_K};
  assign p    = prod[RECIP_SHIFT +: 10];

  always_comb begin
    state_nxt     = state_r;
    btn_nxt       = btn_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cap_we        = 1'b0;
    raw_we        = 1'b0;
    cmd_pop       = 1'b0;
    status_nxt    = status_r;
    span_nxt      = span_r;
    ax_nxt        = ax_r;
    widx_nxt      = widx_r;
    rank_nxt      = rank_r;
    dmag_nxt      = dmag_r;
    smag_nxt      = smag_r;
    qneg_nxt      = qneg_r;
    nmag_nxt      = nmag_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    v_nxt         = v_r;
    sq_nxt        = sq_r;
    vneg_nxt      = vneg_r;
    xpos_nxt      = xpos_r;
    ypos_nxt      = ypos_r;
    axis_done     = 1'b0;
    axis_pos      = 11'sd0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          status_nxt = ST_OK;
          span_nxt   = 1'b0;
          ax_nxt     = 1'b0;
          state_nxt  = B_EXEC;
        end
      end
      B_EXEC: begin
        state_nxt = B_LOAD;
        unique case (cmd.kind)
          K_CAP:    cap_we = 1'b1;
          K_AXIS:   raw_we = 1'b1;
          K_AXBAD:  status_nxt = ST_AXIS;
          K_KEYBAD: status_nxt = ST_NOKEY;
          K_KEY: begin
            widx_nxt  = '0;
            rank_nxt  = '0;
            state_nxt = B_RANK;
          end
          default: ;
        endcase
      end
      B_RANK: begin
        // Sweep the capability words up to the key's own word.
        if (!last_word) begin
          rank_nxt = rank_sum;
          widx_nxt = widx_r + KW'(1);
        end else begin
          state_nxt = B_LOAD;
          if (!word[bitsel]) begin
            status_nxt = ST_NOKEY;
          end else if (rank_sum > RW'(31)) begin
            status_nxt = ST_BIG;
          end else begin
            btn_nxt[rank_sum[4:0]] = cmd.value != 32'd0;
          end
        end
      end
      B_LOAD: begin
        if (!sel_ok) begin
          axis_done = 1'b1;
        end else if (span == 33'sd0) begin
          span_nxt  = 1'b1;
          axis_done = 1'b1;
        end else begin
          dmag_nxt  = diff[32] ? 33'(-diff) : 33'(diff);
          smag_nxt  = span[32] ? 33'(-span) : 33'(span);
          qneg_nxt  = diff[32] ^ span[32];
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        nmag_nxt  = {11'd0, dmag_r} * 44'(SCALE);
        state_nxt = B_CHK;
      end
      B_CHK: begin
        // A quotient of 2048 or more clamps either way.
        if (nmag_r >= {smag_r, 11'd0}) begin
          v_nxt     = qneg_r ? -11'sd1000 : 11'sd1000;
          state_nxt = B_SQ;
        end else begin
          dvs_nxt   = {1'b0, smag_r, 10'd0};
          cnt_nxt   = 4'd10;
          q_nxt     = 11'd0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (nmag_r >= dvs_r) begin
          nmag_nxt = nmag_r - dvs_r;
          q_nxt    = {q_r[9:0], 1'b1};
        end else begin
          q_nxt    = {q_r[9:0], 1'b0};
        end
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = B_CLAMP;
        end
      end
      B_CLAMP: begin
        if (t < -13'sd1000) begin
          v_nxt = -11'sd1000;
        end else if (t > 13'sd1000) begin
          v_nxt = 11'sd1000;
        end else begin
          v_nxt = t[10:0];
        end
        state_nxt = B_SQ;
      end
      B_SQ: begin
        sq_nxt    = {10'd0, vmag} * {10'd0, vmag};
        vneg_nxt  = v_r[10];
        state_nxt = B_REC;
      end
      B_REC: begin
        axis_done = 1'b1;
        axis_pos  = vneg_r ? -$signed({1'b0, p}) : $signed({1'b0, p});
      end
      B_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, span_r, status_r, btn_r, ypos_r, xpos_r};
          cmd_pop       = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    if (axis_done) begin
      if (ax_r) begin
        ypos_nxt  = axis_pos;
        state_nxt = B_OUT;
      end else begin
        xpos_nxt  = axis_pos;
        ax_nxt    = 1'b1;
        state_nxt = B_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      btn_r       <= 32'd0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        cap_r[i] <= 32'd0;
      end
      for (int i = 0; i < AXIS_COUNT; i++) begin
        raw_r[i] <= 32'sd0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      btn_r       <= btn_nxt;
      if (cap_we) begin
        cap_r[cmd.widx[KW-1:0]] <= cmd.word;
      end
      if (raw_we) begin
        raw_r[cmd.code[AW-1:0]] <= cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    status_r   <= status_nxt;
    span_r     <= span_nxt;
    ax_r       <= ax_nxt;
    widx_r     <= widx_nxt;
    rank_r     <= rank_nxt;
    dmag_r     <= dmag_nxt;
    smag_r     <= smag_nxt;
    qneg_r     <= qneg_nxt;
    nmag_r     <= nmag_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    v_r        <= v_nxt;
    sq_r       <= sq_nxt;
    vneg_r     <= vneg_nxt;
    xpos_r     <= xpos_nxt;
    ypos_r     <= ypos_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/joystick_event_to_axes_buttons.sv
// ----------------------------------------------------------------------------
// joystick_event_to_axes_buttons
// Decodes joystick events into two shaped axis positions and button bits.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in_      slave      in_tvalid / in_tready     in_tdata, in_tuser
//  out_     master     out_tvalid / out_tready   out_tdata
//  cfg_     APB        psel, penable, pready     paddr, pwdata, prdata
//
// After a request is accepted, a key event sweeps the capability words one
// per cycle up to its own word, and each selected axis then takes a
// multiply, a range check, an 11-step restoring divider, a clamp and two
// multiply stages before the result is valid. Reset is synchronous
// and clears the capability map, the axis values and the buttons. A
// two-entry queue holds requests while the back end works or waits on
// out_tready.
`default_nettype none

module joystick_event_to_axes_buttons
  import jeab_pkg::*;
#(
  parameter int KEY_BITS   = 768,
  parameter int AXIS_COUNT = 9
)
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // event_type, event_code, event_value, cap_word_index, cap_word, zero pad
  input  wire logic [103:0] in_tdata,
  // func
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // x_position, y_position, button_bits, event_status, span_error, zero pad
  output logic [63:0]       out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_full, q_push, q_valid, q_pop;
  logic [$bits(cmd_t)-1:0] q_head;

  assign back_cmd = cmd_t'(q_head);

  jeab_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  jeab_front #(
    .KEY_BITS   (KEY_BITS),
    .AXIS_COUNT (AXIS_COUNT)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .cmd       (front_cmd)
  );

  jeab_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  jeab_back #(
    .KEY_BITS   (KEY_BITS),
    .AXIS_COUNT (AXIS_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (back_cmd),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/jeab_checker.sv
// ----------------------------------------------------------------------------
// jeab_checker
// Port-level checks of the joystick event decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jeab_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic         cfg_pready
);

  logic signed [10:0] xp, yp;

  assign xp = out_tdata[10:0];
  assign yp = out_tdata[21:11];

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the output stage.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Shaped positions stay within the clamp range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> xp >= -11'sd1000 && xp <= 11'sd1000 &&
                   yp >= -11'sd1000 && yp <= 11'sd1000)
    else $error("position out of range");

  // A zero span forces at least one position to zero.
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[56] |-> xp == 11'sd0 || yp == 11'sd0)
    else $error("span error with two nonzero positions");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind joystick_event_to_axes_buttons jeab_checker u_chk (.*);

`default_nettype wire
